[design/abhp_pkg.sv]
// ============================================================================
// Audio block header parser: shared package
// Types, codes and fixed limits used by the front end, the queue and the
// back end of the block header parser and gap tracker.
// ============================================================================
package abhp_pkg;

  // Field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned RATE_W   = 19;
  localparam int unsigned CHAN_W   = 4;
  localparam int unsigned TIME_W   = 64;
  localparam int unsigned LEN_W    = 24;
  localparam int unsigned DUR_W    = 24;
  localparam int unsigned GAP_W    = 64;
  localparam int unsigned SEEN_W   = 25;
  localparam int unsigned DIV_W    = 34;
  localparam int unsigned OUT_W    = 216;

  // Protocol limits
  localparam int unsigned RATE_MAX        = 384000;
  localparam int unsigned CHAN_MAX        = 8;
  localparam int unsigned MS_PER_SEC      = 1000;
  localparam int unsigned VARINT_MAX_BYTES = 10;
  localparam logic [SEEN_W-1:0] SEEN_MAX  = '1;
  localparam logic [DUR_W-1:0]  DUR_MAX   = '1;
  localparam logic [LEN_W-1:0]  MAX_BLOCK_RESET = 24'h100000;

  // Register map: index bit of the byte address
  localparam logic REG_MAX_BLOCK = 1'b0;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_REPORT  = 1'b1;

  typedef enum logic [2:0] {
    PH_RATE, PH_CHAN, PH_TIME, PH_LEN, PH_DATA, PH_SKIP
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_TRUNC = 2'd1,
    ST_PROTO = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    B_IDLE, B_DIV1, B_START2, B_DIV2, B_GAP, B_EMIT
  } back_state_e;

  // Work for one input byte, handed from the front end to the back end
  typedef struct packed {
    logic               has_byte;
    logic [BYTE_W-1:0]  body_byte;
    logic               has_report;
    status_e            status;
    logic [RATE_W-1:0]  rate;
    logic [CHAN_W-1:0]  chan;
    logic [TIME_W-1:0]  stamp;
    logic [LEN_W-1:0]   len;
  } entry_t;

endpackage

[design/audio_block_header_parser_gap_tracker_core.sv]
// ============================================================================
// Audio block header parser and gap tracker
// Parses audio block bodies byte by byte, forwards payload bytes and reports
// status, header, duration and accumulated timestamp gap per block.
// ============================================================================
//
// Channel   Direction  Transaction
// s_axis    in         one body byte; tlast marks the end of the block
// m_axis    out        payload byte or end-of-block report; tuser is the kind
// APB       in/out     max_block_bytes register at byte address 0
//
// Header and payload bytes are taken at one per cycle while the work queue
// has room; payload bytes leave at one per cycle while the result stream is
// not stalled and no report is being worked out. An end-of-block report for a
// good block is worked out in the back end by two passes of the 34-step
// bit-serial divider. Reports for failed blocks skip the divider. Queue depth is QUEUE_DEPTH.
// Reset is asynchronous and active low; no clearing pass is needed.
// A stalled result stream fills the queue and then stalls input.
module audio_block_header_parser_gap_tracker_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] body_byte
  input  logic         s_axis_tlast,   // end_of_block
  // Result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [7:0] pcm_byte, [9:8] status, [28:10] rate_hz, [32:29] channel_count,
  // [96:33] block_time, [120:97] payload_length, [144:121] duration_ms,
  // [208:145] gap_total, [215:209] zero
  output logic [215:0] m_axis_tdata,
  output logic         m_axis_tlast,   // final_result
  output logic         m_axis_tuser,   // [0] kind
  // Configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import abhp_pkg::*;

  logic               full;
  logic               empty;
  logic               push;
  logic               pop;
  logic               accept;
  entry_t             push_entry;
  entry_t             head;
  logic [LEN_W-1:0]   max_block_q;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_BLOCK) ? {8'd0, max_block_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_block_q <= MAX_BLOCK_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MAX_BLOCK)) begin
      max_block_q <= pwdata[LEN_W-1:0];
    end
  end

  abhp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .body_byte_i    (s_axis_tdata),
    .end_of_block_i (s_axis_tlast),
    .max_block_i    (max_block_q),
    .push_o         (push),
    .entry_o        (push_entry)
  );

  abhp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (head)
  );

  abhp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .empty_i       (empty),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

[design/abhp_front.sv]
// ============================================================================
// Audio block header parser: front end
// Parses the block header one accepted byte per cycle, checks ranges, counts
// payload bytes and turns payload bytes and block ends into back-end work entries.
// ============================================================================
module abhp_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [7:0]                body_byte_i,
  input  logic                      end_of_block_i,
  input  logic [23:0]               max_block_i,
  output logic                      push_o,
  output abhp_pkg::entry_t          entry_o
);
  import abhp_pkg::*;

  phase_e              phase_q, phase_d;
  logic [63:0]         acc_q, acc_d;
  logic [3:0]          cnt_q, cnt_d;
  logic [RATE_W-1:0]   rate_q, rate_d;
  logic                rate_ok_q, rate_ok_d;
  logic [7:0]          chan_q, chan_d;
  logic [TIME_W-1:0]   stamp_q, stamp_d;
  logic [LEN_W-1:0]    len_q, len_d;
  logic [SEEN_W-1:0]   seen_q, seen_d;
  logic                err_q, err_d;

  logic [6:0]          shamt;
  logic [63:0]         merged;
  logic                chan_ok;
  logic                len_ok;
  status_e             status;

  // Varint byte placed at seven bits per byte already taken
  assign shamt   = 7'({3'b000, cnt_q} * 7'd7);
  assign merged  = acc_q | ({57'd0, body_byte_i[6:0]} << shamt);
  assign chan_ok = (chan_q != 8'd0) && (chan_q <= 8'(CHAN_MAX));
  assign len_ok  = (merged != 64'd0) && (merged <= {40'd0, max_block_i});

  // Parser next state and work entry
  always_comb begin
    phase_d   = phase_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    rate_d    = rate_q;
    rate_ok_d = rate_ok_q;
    chan_d    = chan_q;
    stamp_d   = stamp_q;
    len_d     = len_q;
    seen_d    = seen_q;
    err_d     = err_q;
    status    = ST_OK;
    push_o    = 1'b0;
    entry_o   = '0;
    if (accept_i) begin
      unique case (phase_q)
        PH_RATE, PH_TIME, PH_LEN: begin
          if (cnt_q == 4'(VARINT_MAX_BYTES)) begin
            err_d   = 1'b1;
            phase_d = PH_SKIP;
          end else if (!body_byte_i[7]) begin
            acc_d = '0;
            cnt_d = '0;
            if (phase_q == PH_RATE) begin
              rate_d    = merged[RATE_W-1:0];
              rate_ok_d = (merged != 64'd0) && (merged <= 64'(RATE_MAX));
              phase_d   = PH_CHAN;
            end else if (phase_q == PH_TIME) begin
              stamp_d = merged;
              phase_d = PH_LEN;
            end else begin
              len_d = merged[LEN_W-1:0];
              if (!(rate_ok_q && chan_ok && len_ok)) begin
                err_d   = 1'b1;
                phase_d = PH_SKIP;
              end else begin
                phase_d = PH_DATA;
                seen_d  = '0;
              end
            end
          end else begin
            acc_d = merged;
            cnt_d = cnt_q + 4'd1;
          end
        end
        PH_CHAN: begin
          chan_d  = body_byte_i;
          phase_d = PH_TIME;
        end
        PH_DATA: begin
          if (seen_q != SEEN_MAX) begin
            seen_d = seen_q + 1'b1;
          end
        end
        PH_SKIP: begin
        end
        default: begin
          phase_d = PH_RATE;
        end
      endcase

      entry_o.has_byte  = (phase_q == PH_DATA);
      entry_o.body_byte = body_byte_i;

      // End of block: status from the state after this byte, then restart
      if (end_of_block_i) begin
        if (err_d) begin
          status = ST_PROTO;
        end else if (phase_d == PH_DATA) begin
          status = (seen_d == {1'b0, len_d}) ? ST_OK : ST_PROTO;
        end else begin
          status = ST_TRUNC;
        end
        entry_o.has_report = 1'b1;
        entry_o.status     = status;
        entry_o.rate       = rate_d;
        entry_o.chan       = chan_d[CHAN_W-1:0];
        entry_o.stamp      = stamp_d;
        entry_o.len        = len_d;
        phase_d = PH_RATE;
        acc_d   = '0;
        cnt_d   = '0;
        seen_d  = '0;
        err_d   = 1'b0;
      end
      push_o = entry_o.has_byte || entry_o.has_report;
    end
  end

  // Parser control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_RATE;
      acc_q   <= '0;
      cnt_q   <= '0;
      seen_q  <= '0;
      err_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      seen_q  <= seen_d;
      err_q   <= err_d;
    end
  end

  // Held header fields
  always_ff @(posedge clk_i) begin
    rate_q    <= rate_d;
    rate_ok_q <= rate_ok_d;
    chan_q    <= chan_d;
    stamp_q   <= stamp_d;
    len_q     <= len_d;
  end

endmodule

[design/abhp_queue.sv]
// ============================================================================
// Audio block header parser: work queue
// Short first-in first-out queue of work entries between front and back end.
// ============================================================================
module abhp_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  abhp_pkg::entry_t  data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output abhp_pkg::entry_t  data_o
);
  import abhp_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  entry_t            mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [CNT_W-1:0]  cnt_q;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[design/abhp_div.sv]
// ============================================================================
// Audio block header parser: divider
// Restoring divider, one quotient bit per cycle; done pulses for one cycle
// when the quotient is ready.
// ============================================================================
module abhp_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [abhp_pkg::DIV_W-1:0]  dividend_i,
  input  logic [abhp_pkg::RATE_W-1:0] divisor_i,
  output logic                        done_o,
  output logic [abhp_pkg::DIV_W-1:0]  quotient_o
);
  import abhp_pkg::*;

  localparam int unsigned STEP_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]  quo_q;
  logic [RATE_W-1:0] rem_q;
  logic [RATE_W-1:0] den_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q;
  logic              done_q;
  logic [RATE_W:0]   trial;
  logic              fits;

  // One restoring step
  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign fits  = (trial >= {1'b0, den_q});

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_W-2:0], fits};
      rem_q <= fits ? RATE_W'(trial - {1'b0, den_q}) : trial[RATE_W-1:0];
    end
  end

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        step_q <= STEP_W'(DIV_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

[design/abhp_back.sv]
// ============================================================================
// Audio block header parser: back end
// Drains work entries, forwards payload bytes, works out block duration and
// gap total for good blocks and drives the result stream register.
// ============================================================================
module abhp_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  abhp_pkg::entry_t            head_i,
  input  logic                        empty_i,
  output logic                        pop_o,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [abhp_pkg::OUT_W-1:0]  m_axis_tdata,
  output logic                        m_axis_tlast,
  output logic                        m_axis_tuser
);
  import abhp_pkg::*;

  back_state_e        state_q, state_d;
  entry_t             rep_q;
  logic [DIV_W-1:0]   prod_q;
  logic [DIV_W-1:0]   dur_q;
  logic [GAP_W-1:0]   gap_q;
  logic [TIME_W-1:0]  exp_q;
  logic               primed_q;

  logic               out_valid_q;
  logic [OUT_W-1:0]   out_data_q;
  logic               out_last_q;
  logic               out_user_q;

  logic               load_ok;
  logic               out_load;
  logic [OUT_W-1:0]   out_data;
  logic               out_last;
  logic               out_user;
  logic               latch;
  logic               div_start;
  logic [DIV_W-1:0]   div_dividend;
  logic [RATE_W-1:0]  div_divisor;
  logic               div_done;
  logic [DIV_W-1:0]   div_quot;
  logic [DUR_W-1:0]   dur_sat;
  logic               rep_ok;

  assign load_ok = !out_valid_q || m_axis_tready;
  assign dur_sat = (dur_q > DIV_W'(DUR_MAX)) ? DUR_MAX : dur_q[DUR_W-1:0];
  assign rep_ok  = (rep_q.status == ST_OK);

  abhp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Sequencer outputs
  always_comb begin
    pop_o        = 1'b0;
    out_load     = 1'b0;
    out_data     = '0;
    out_last     = 1'b0;
    out_user     = KIND_PAYLOAD;
    latch        = 1'b0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          if (head_i.has_byte) begin
            if (load_ok) begin
              out_load = 1'b1;
              out_data = OUT_W'(head_i.body_byte);
              out_last = !head_i.has_report;
              pop_o    = 1'b1;
            end
          end else begin
            pop_o = 1'b1;
          end
          if (pop_o && head_i.has_report) begin
            latch = 1'b1;
            if (head_i.status == ST_OK) begin
              div_start    = 1'b1;
              div_dividend = DIV_W'(head_i.len);
              div_divisor  = RATE_W'({head_i.chan, 1'b0});
            end
          end
        end
      end
      B_START2: begin
        div_start    = 1'b1;
        div_dividend = prod_q;
        div_divisor  = rep_q.rate;
      end
      B_EMIT: begin
        if (load_ok) begin
          out_load = 1'b1;
          out_last = 1'b1;
          out_user = KIND_REPORT;
          if (rep_ok) begin
            out_data = {7'd0, gap_q, dur_sat, rep_q.len, rep_q.stamp, rep_q.chan,
                        rep_q.rate, rep_q.status, 8'd0};
          end else begin
            out_data = {7'd0, gap_q, 135'd0, rep_q.status, 8'd0};
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (pop_o && head_i.has_report) begin
          state_d = (head_i.status == ST_OK) ? B_DIV1 : B_EMIT;
        end
      end
      B_DIV1: begin
        if (div_done) begin
          state_d = B_START2;
        end
      end
      B_START2: state_d = B_DIV2;
      B_DIV2: begin
        if (div_done) begin
          state_d = B_GAP;
        end
      end
      B_GAP: state_d = B_EMIT;
      B_EMIT: begin
        if (load_ok) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // Report working registers
  always_ff @(posedge clk_i) begin
    if (latch) begin
      rep_q <= head_i;
    end
    if (state_q == B_DIV1 && div_done) begin
      prod_q <= DIV_W'(div_quot[LEN_W-1:0]) * DIV_W'(MS_PER_SEC);
    end
    if (state_q == B_DIV2 && div_done) begin
      dur_q <= div_quot;
    end
  end

  // Sequencer state and gap tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      gap_q    <= '0;
      exp_q    <= '0;
      primed_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_GAP && primed_q && (rep_q.stamp > exp_q)) begin
        gap_q <= gap_q + (rep_q.stamp - exp_q);
      end
      if (state_q == B_EMIT && out_load && rep_ok) begin
        exp_q    <= rep_q.stamp + TIME_W'(dur_q);
        primed_q <= 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= out_data;
      out_last_q <= out_last;
      out_user_q <= out_user;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_user_q;

`ifndef NO_ASSERTIONS
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == B_DIV1 || state_q == B_DIV2))
    else $error("divider finished outside a divide state");

  a_primed_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    primed_q |=> primed_q)
    else $error("primed flag cleared");

  a_bad_block_keeps_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_EMIT && out_load && !rep_ok) |=> ($stable(gap_q) && $stable(exp_q)))
    else $error("failed block changed gap tracking state");

  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !out_load)
    else $error("result register overwritten while stalled");
`endif

endmodule

[tb/sv/audio_block_checker.sv]
// ============================================================================
// Audio block parser result checker
// Watches the body byte, result and register channels of the block header
// parser, works out the results that each accepted byte should cause and
// compares every accepted result with the oldest one still awaited.
// ============================================================================
module audio_block_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,
  input  logic         s_axis_tlast,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [215:0] m_axis_tdata,
  input  logic         m_axis_tlast,
  input  logic         m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic [31:0]  prdata,
  input  logic         pready,
  output int           errors_o,
  output int           awaited_o,
  output int           checked_o,
  output int           good_blocks_o
);
  import abhp_pkg::*;

  // One result transaction, split into its fields
  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] pcm;
    status_e           status;
    logic [RATE_W-1:0] rate;
    logic [CHAN_W-1:0] chan;
    logic [TIME_W-1:0] stamp;
    logic [LEN_W-1:0]  len;
    logic [DUR_W-1:0]  dur;
    logic [GAP_W-1:0]  gap;
    logic              last;
  } result_t;

  result_t due_results[$];

  // Parser and gap tracker state
  logic [LEN_W-1:0]  limit;
  phase_e            phase;
  logic [63:0]       vacc;
  int unsigned       vshift;
  logic [63:0]       hrate;
  logic [7:0]        hchan;
  logic [63:0]       htime;
  logic [63:0]       hlen;
  logic [SEEN_W-1:0] seen;
  status_e           err;
  logic [63:0]       next_start;
  logic [63:0]       gap_sum;
  bit                primed;

  int n_errors = 0;
  int n_checked = 0;
  int n_good = 0;
  int n_awaited = 0;

  assign errors_o      = n_errors;
  assign awaited_o     = n_awaited;
  assign checked_o     = n_checked;
  assign good_blocks_o = n_good;

  function automatic string describe(input result_t r);
    return $sformatf({"kind %0d byte %02h status %0d rate %0d chan %0d time %0h ",
                      "len %0d dur %0d gap %0h last %0b"}, r.kind, r.pcm, r.status,
                     r.rate, r.chan, r.stamp, r.len, r.dur, r.gap, r.last);
  endfunction

  // Only the first few failures are described in full.
  function automatic void note_failure(input string msg);
    n_errors++;
    if (n_errors <= 10) $display("error: %s", msg);
  endfunction

  function automatic void reset_state();
    limit      = MAX_BLOCK_RESET;
    phase      = PH_RATE;
    vacc       = '0;
    vshift     = 0;
    hrate      = '0;
    hchan      = '0;
    htime      = '0;
    hlen       = '0;
    seen       = '0;
    err        = ST_OK;
    next_start = '0;
    gap_sum    = '0;
    primed     = 1'b0;
    due_results.delete();
  endfunction

  function automatic void enter_skip();
    err   = ST_PROTO;
    phase = PH_SKIP;
  endfunction

  // Works out the results caused by one body byte and queues them.
  function automatic void parse_body_byte(input logic [7:0] b, input logic eob);
    logic [63:0] frames;
    logic [63:0] span;
    result_t     r;
    bit          done;
    bit          too_long;
    status_e     st;
    done     = 1'b0;
    too_long = 1'b0;
    case (phase)
      PH_RATE, PH_TIME, PH_LEN: begin
        // Base-128 varint; an eleventh byte is a protocol error
        if (vshift > 63) begin
          too_long = 1'b1;
        end else begin
          vacc |= 64'(b[6:0]) << vshift;
          if (b[7]) vshift += 7;
          else done = 1'b1;
        end
        if (too_long) begin
          enter_skip();
        end else if (done) begin
          if (phase == PH_RATE) begin
            hrate = vacc;
            phase = PH_CHAN;
          end else if (phase == PH_TIME) begin
            htime = vacc;
            phase = PH_LEN;
          end else begin
            hlen = vacc;
            // Range checks wait until the whole header is in
            if (hrate == 0 || hrate > RATE_MAX || hchan == 0 || hchan > CHAN_MAX ||
                hlen == 0 || hlen > 64'(limit)) begin
              enter_skip();
            end else begin
              phase = PH_DATA;
              seen  = '0;
            end
          end
          vacc   = '0;
          vshift = 0;
        end
      end
      PH_CHAN: begin
        hchan = b;
        phase = PH_TIME;
      end
      PH_DATA: begin
        r      = '0;
        r.kind = KIND_PAYLOAD;
        r.pcm  = b;
        r.last = !eob;
        due_results.push_back(r);
        if (seen != SEEN_MAX) seen++;
      end
      default: ;
    endcase

    if (eob) begin
      // The first error recorded takes precedence over later ones.
      if (err != ST_OK) st = err;
      else if (phase == PH_DATA) st = (64'(seen) == hlen) ? ST_OK : ST_PROTO;
      else st = ST_TRUNC;
      r        = '0;
      r.kind   = KIND_REPORT;
      r.status = st;
      if (st == ST_OK) begin
        frames = hlen / (64'(hchan) * 2);
        span   = frames * MS_PER_SEC / hrate;
        if (primed && htime > next_start) gap_sum += htime - next_start;
        next_start = htime + span;
        primed     = 1'b1;
        r.rate  = hrate[RATE_W-1:0];
        r.chan  = hchan[CHAN_W-1:0];
        r.stamp = htime;
        r.len   = hlen[LEN_W-1:0];
        r.dur   = (span > 64'(DUR_MAX)) ? DUR_MAX : span[DUR_W-1:0];
        n_good++;
      end
      r.gap  = gap_sum;
      r.last = 1'b1;
      due_results.push_back(r);
      phase  = PH_RATE;
      vacc   = '0;
      vshift = 0;
      seen   = '0;
      err    = ST_OK;
    end
  endfunction

  // Compares one result transaction with the oldest awaited result.
  function automatic void check_result();
    result_t got;
    result_t want;
    string   bad = "";
    got.kind   = m_axis_tuser;
    got.pcm    = m_axis_tdata[7:0];
    got.status = status_e'(m_axis_tdata[9:8]);
    got.rate   = m_axis_tdata[28:10];
    got.chan   = m_axis_tdata[32:29];
    got.stamp  = m_axis_tdata[96:33];
    got.len    = m_axis_tdata[120:97];
    got.dur    = m_axis_tdata[144:121];
    got.gap    = m_axis_tdata[208:145];
    got.last   = m_axis_tlast;
    n_checked++;
    if (due_results.size() == 0) begin
      note_failure({"result with nothing awaited: ", describe(got)});
      return;
    end
    want = due_results.pop_front();
    if (got.kind !== want.kind) bad = {bad, " kind"};
    if (got.pcm !== want.pcm) bad = {bad, " pcm_byte"};
    if (got.status !== want.status) bad = {bad, " status"};
    if (got.rate !== want.rate) bad = {bad, " rate_hz"};
    if (got.chan !== want.chan) bad = {bad, " channel_count"};
    if (got.stamp !== want.stamp) bad = {bad, " block_time"};
    if (got.len !== want.len) bad = {bad, " payload_length"};
    if (got.dur !== want.dur) bad = {bad, " duration_ms"};
    if (got.gap !== want.gap) bad = {bad, " gap_total"};
    if (got.last !== want.last) bad = {bad, " final_result"};
    if (bad != "")
      note_failure($sformatf("result %0d differs in%s\n  expected %s\n  actual   %s",
                             n_checked, bad, describe(want), describe(got)));
  endfunction

  // Results are compared before the same edge's input is predicted, so a
  // byte never matches a result it could not yet have caused.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_state();
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (s_axis_tvalid && s_axis_tready) parse_body_byte(s_axis_tdata, s_axis_tlast);
      if (psel && penable && pready && paddr[2] == REG_MAX_BLOCK) begin
        if (pwrite) limit = pwdata[LEN_W-1:0];
        else if (prdata !== {8'd0, limit})
          note_failure($sformatf("register read %h, expected %h", prdata, limit));
      end
    end
    n_awaited = due_results.size();
  end

endmodule

[tb/sv/tb.sv]
// ============================================================================
// Audio block header parser testbench
// Feeds block bodies byte by byte: a directed set of header, range, length
// and truncation cases, then random blocks under four pacing phases and
// several length limits. A separate checker predicts and compares results.
// ============================================================================
module tb;
  import abhp_pkg::*;

  localparam int RANDOM_BYTES  = 950;
  localparam int SETTLE_CYCLES = 150;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [215:0] m_axis_tdata;
  logic         m_axis_tlast;
  logic         m_axis_tuser;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  int fail_count;
  int awaited;
  int checked;
  int good_blocks;

  logic [7:0]  blk[$];
  logic [63:0] last_stamp = '0;
  int unsigned limit_now = MAX_BLOCK_RESET;
  int          send_idle = 0;
  int          recv_stall = 0;
  int          bytes_sent = 0;
  int          blocks_sent = 0;

  audio_block_header_parser_gap_tracker_core dut (.*);

  audio_block_checker report_check (
    .*,
    .errors_o      (fail_count),
    .awaited_o     (awaited),
    .checked_o     (checked),
    .good_blocks_o (good_blocks)
  );

  always #5 clk_i = ~clk_i;

  // Result side back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall);
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results still awaited", awaited);
    $display("tb: failure");
    $finish;
  end

  // Appends a varint, now and then with redundant continuation bytes.
  function automatic void add_varint(input logic [63:0] v);
    logic [63:0] rest;
    int          pad;
    rest = v;
    pad  = (v < 64'h8_0000_0000 && $urandom_range(7) == 0) ? $urandom_range(1, 2) : 0;
    while (rest > 64'd127) begin
      blk.push_back({1'b1, rest[6:0]});
      rest = rest >> 7;
    end
    if (pad == 0) begin
      blk.push_back({1'b0, rest[6:0]});
    end else begin
      blk.push_back({1'b1, rest[6:0]});
      repeat (pad - 1) blk.push_back(8'h80);
      blk.push_back(8'h00);
    end
  endfunction

  function automatic void add_noise(input int n);
    repeat (n) blk.push_back(8'($urandom));
  endfunction

  function automatic void hdr_block(input logic [63:0] rate, input logic [7:0] chan,
                                    input logic [63:0] stamp, input logic [63:0] len,
                                    input int npay);
    blk.delete();
    add_varint(rate);
    blk.push_back(chan);
    add_varint(stamp);
    add_varint(len);
    add_noise(npay);
  endfunction

  function automatic logic [63:0] pick_rate();
    case ($urandom_range(3))
      0: return 64'd1;
      1: return 64'(RATE_MAX);
      2: return 64'd48000;
      default: return 64'($urandom_range(1, RATE_MAX));
    endcase
  endfunction

  // Timestamps mostly follow on from the previous one, so gaps stay small.
  function automatic logic [63:0] next_stamp();
    case ($urandom_range(9))
      0: last_stamp = {$urandom, $urandom};
      1: last_stamp = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 50);
      2: last_stamp = last_stamp - $urandom_range(0, 100);
      default: last_stamp = last_stamp + $urandom_range(0, 3000);
    endcase
    return last_stamp;
  endfunction

  // Offers one body byte and returns at the edge where it is accepted.
  task automatic put_byte(input logic [7:0] b, input logic eob);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eob;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_block();
    foreach (blk[i]) put_byte(blk[i], i == blk.size() - 1);
    blocks_sent++;
  endtask

  // Holds the input back until every awaited result has come, then lets the
  // back end settle.
  task automatic wait_drained();
    int guard = 0;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (awaited != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One register transaction: setup cycle, then access cycle.
  task automatic apb_cycle(input logic wr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {REG_MAX_BLOCK, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    int unsigned limits[4];
    int          base;
    int          kind;
    int          pos;
    logic [63:0] rate;
    logic [7:0]  chan;
    logic [63:0] stamp;
    logic [63:0] len;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed blocks at the reset length limit, no idling
    hdr_block(1, 1, 0, 1, 1);                        // smallest good block
    send_block();
    hdr_block(RATE_MAX, CHAN_MAX, 64'hFFFF_FFFF_FFFF_FFFF, 16, 16);  // big gap
    send_block();
    hdr_block(48000, 2, 5, 4, 4);                    // timestamp runs backwards
    send_block();
    hdr_block(0, 2, 5, 4, 4);                        // rate zero
    send_block();
    hdr_block(RATE_MAX + 1, 2, 5, 4, 4);             // rate just too high
    send_block();
    hdr_block(8000, 0, 5, 4, 4);                     // no channels
    send_block();
    hdr_block(8000, CHAN_MAX + 1, 5, 4, 4);          // one channel too many
    send_block();
    hdr_block(8000, 8'hFF, 5, 4, 4);
    send_block();
    hdr_block(8000, 1, 5, 0, 0);                     // empty payload
    send_block();
    hdr_block(8000, 1, 5, MAX_BLOCK_RESET + 1, 0);   // length over the limit
    send_block();
    hdr_block(8000, 1, 5, MAX_BLOCK_RESET, 0);       // length at the limit, no data
    send_block();
    hdr_block(8000, 1, 100, 8, 5);                   // payload too short
    send_block();
    hdr_block(8000, 1, 200, 8, 11);                  // payload too long
    send_block();
    blk.delete();                                    // ends inside the header
    blk.push_back(8'h01);
    send_block();
    hdr_block(0, 0, 7, 3, 0);                        // truncated beats range failure
    void'(blk.pop_back());
    send_block();
    blk.delete();                                    // over-long rate varint
    repeat (11) blk.push_back(8'h80);
    blk.push_back(8'h01);
    send_block();
    blk.delete();                                    // tenth varint byte loses its high bits
    add_varint(1000);
    blk.push_back(8'd2);
    repeat (9) blk.push_back(8'hFF);
    blk.push_back(8'h7F);
    add_varint(4);
    add_noise(4);
    send_block();
    hdr_block(1, 1, 3000, 40, 40);                   // long duration at the slowest rate
    send_block();

    // Random blocks under four pacing phases and four length limits
    limits[0] = 24'hFF_FFFF;
    limits[1] = 1;
    limits[2] = $urandom_range(2, 64);
    limits[3] = $urandom_range(65, 24'hFF_FFFF);
    base = bytes_sent;
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      apb_cycle(1'b1, limits[ph]);
      @(posedge clk_i);
      apb_cycle(1'b0, '0);
      @(posedge clk_i);
      limit_now  = limits[ph];
      send_idle  = (ph == 1) ? 63 : (ph == 3) ? 13 : 0;
      recv_stall = (ph == 2) ? 63 : (ph == 3) ? 13 : 0;
      while (bytes_sent - base < (ph + 1) * RANDOM_BYTES / 4) begin
        if ($urandom_range(24) == 0) wait_drained();
        kind  = $urandom_range(99);
        rate  = pick_rate();
        chan  = 8'($urandom_range(1, CHAN_MAX));
        stamp = next_stamp();
        len   = 64'($urandom_range(1, (limit_now < 40) ? limit_now : 40));
        if (kind < 60) begin
          hdr_block(rate, chan, stamp, len, len);
        end else if (kind < 65) begin
          hdr_block(rate, chan, stamp, len + 1, $urandom_range(0, len));
        end else if (kind < 70) begin
          hdr_block(rate, chan, stamp, len, len + $urandom_range(1, 4));
        end else if (kind < 75) begin
          case ($urandom_range(2))
            0: rate = 0;
            1: rate = 64'(RATE_MAX) + 1 + $urandom_range(0, 1000);
            default: rate = {1'b1, 31'($urandom), 32'($urandom)};
          endcase
          hdr_block(rate, chan, stamp, len, $urandom_range(0, 4));
        end else if (kind < 80) begin
          chan = $urandom_range(1) ? 8'd0 : 8'($urandom_range(CHAN_MAX + 1, 255));
          hdr_block(rate, chan, stamp, len, $urandom_range(0, 4));
        end else if (kind < 85) begin
          case ($urandom_range(2))
            0: len = 0;
            1: len = 64'(limit_now) + 1 + $urandom_range(0, 3);
            default: len = {$urandom, $urandom};
          endcase
          hdr_block(rate, chan, stamp, len, $urandom_range(0, 4));
        end else if (kind < 90) begin
          hdr_block($urandom_range(1) ? rate : 64'($urandom), 8'($urandom), stamp, len, 0);
          repeat ($urandom_range(1, blk.size() - 1)) void'(blk.pop_back());
        end else if (kind < 95) begin
          blk.delete();
          pos = $urandom_range(2);
          if (pos > 0) begin
            add_varint(rate);
            blk.push_back(chan);
          end
          if (pos > 1) add_varint(stamp);
          repeat (10) blk.push_back({1'b1, 7'($urandom)});
          add_noise($urandom_range(1, 6));
        end else begin
          blk.delete();
          add_noise($urandom_range(1, 16));
        end
        send_block();
      end
    end

    wait_drained();
    $display("summary: %0d body bytes in %0d blocks, length limits from 1 to 16777215",
             bytes_sent, blocks_sent);
    $display("summary: %0d results compared, %0d good-block reports", checked, good_blocks);
    if (awaited != 0) $display("%0d awaited results never arrived", awaited);
    if (fail_count == 0 && awaited == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

[filelist.f]
design/abhp_pkg.sv
design/abhp_front.sv
design/abhp_queue.sv
design/abhp_div.sv
design/abhp_back.sv
design/audio_block_header_parser_gap_tracker_core.sv
tb/sv/audio_block_checker.sv
tb/sv/tb.sv
